/* design/mm_pkg.sv */
// ----------------------------------------------------------------------------
// Matrix multiply package
// Payload types, beat control, register indexes and state codes shared by
// the multiply cells and the top level.
// ----------------------------------------------------------------------------
package mm_pkg;

   // Element width of A, B and the product, signed Q8.8.
   localparam int ELEM_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 4;

   // Request operation codes.
   localparam logic [1:0] OP_LOAD_A  = 2'd0;
   localparam logic [1:0] OP_LOAD_B  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_COLS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_ROWS = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS = 4'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic [2:0]               row;
      logic [2:0]               col;
      logic signed [ELEM_W-1:0] value;
   } mm_req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] result;
      logic [2:0]               out_row;
      logic [2:0]               out_col;
      logic                     last;
      logic                     dim_error;
   } mm_rsp_type;

   // Control that travels with each element of A along the chain.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mm_beat_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DRAIN,
      ST_ERROR
   } mm_state_type;

endpackage

/* design/mm_cell.sv */
// ----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one column of B, multiplies the A elements that pass along the chain
// by it, accumulates one product element and shifts results out in a row.
// ----------------------------------------------------------------------------
module mm_cell #(
   parameter int MAX_DIM = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [mm_pkg::ELEM_W-1:0] a_in,
   input  logic [$clog2(MAX_DIM)-1:0]       p_in,
   input  mm_pkg::mm_beat_ctrl_type         ctl_in,
   output logic signed [mm_pkg::ELEM_W-1:0] a_out,
   output logic [$clog2(MAX_DIM)-1:0]       p_out,
   output mm_pkg::mm_beat_ctrl_type         ctl_out,
   input  logic                             b_we,
   input  logic [$clog2(MAX_DIM)-1:0]       b_addr,
   input  logic signed [mm_pkg::ELEM_W-1:0] b_data,
   input  logic                             load_res,
   input  logic                             shift_res,
   input  logic signed [mm_pkg::ELEM_W-1:0] res_in,
   output logic signed [mm_pkg::ELEM_W-1:0] res_out,
   output logic                             done
);

   localparam int DW    = $clog2(MAX_DIM);
   localparam int EW    = mm_pkg::ELEM_W;
   localparam int PW    = 2 * EW;
   localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
   localparam int SH_W  = ACC_W - mm_pkg::FRAC_BITS;

   logic signed [EW-1:0]    b_mem [MAX_DIM];
   logic signed [EW-1:0]    a_pass_ff;
   logic [DW-1:0]           p_pass_ff;
   mm_pkg::mm_beat_ctrl_type ctl_pass_ff, ctl1_ff, ctl2_ff;
   logic signed [EW-1:0]    b_rd_ff, a1_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [EW-1:0]    res_ff, sat_val;
   logic signed [SH_W-1:0]  shifted;
   logic                    done_ff;

   // Column store of B, written by loads and read at the passing index.
   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[b_addr] <= b_data;
      end
      b_rd_ff <= b_mem[p_in];
      a1_ff   <= a_in;
   end

   // Hand the element on to the neighbour and run the MAC stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_pass_ff <= '0;
         ctl1_ff     <= '0;
         ctl2_ff     <= '0;
         done_ff     <= 1'b0;
      end else begin
         ctl_pass_ff <= ctl_in;
         ctl1_ff     <= ctl_in;
         ctl2_ff     <= ctl1_ff;
         done_ff     <= ctl2_ff.vld && ctl2_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      a_pass_ff <= a_in;
      p_pass_ff <= p_in;
      prod_ff   <= a1_ff * b_rd_ff;
      acc_ff    <= acc_in;
   end

   // The first term of a sum replaces the accumulator.
   always_comb begin
      acc_in = acc_ff;
      if (ctl2_ff.vld) begin
         if (ctl2_ff.first) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Scale back to Q8.8 and saturate.
   always_comb begin
      shifted = SH_W'(acc_ff >>> mm_pkg::FRAC_BITS);
      if (!shifted[SH_W-1] && (|shifted[SH_W-2:EW-1])) begin
         sat_val = {1'b0, {(EW-1){1'b1}}};
      end else if (shifted[SH_W-1] && !(&shifted[SH_W-2:EW-1])) begin
         sat_val = {1'b1, {(EW-1){1'b0}}};
      end else begin
         sat_val = shifted[EW-1:0];
      end
   end

   // Result row: loaded from the accumulator, then shifted towards cell 0.
   always_ff @(posedge clock) begin
      if (load_res) begin
         res_ff <= sat_val;
      end else if (shift_res) begin
         res_ff <= res_in;
      end
   end

   assign a_out   = a_pass_ff;
   assign p_out   = p_pass_ff;
   assign ctl_out = ctl_pass_ff;
   assign res_out = res_ff;
   assign done    = done_ff;

endmodule

/* design/matrix_multiply.sv */
// ----------------------------------------------------------------------------
// Matrix multiply
// C = A * B on signed Q8.8 elements, computed by a chain of MAC cells.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_valid/req_ready with req_data. A load beat
// (op 0 or 1) writes one element of A or B. A compute beat emits the
// product row-major on rsp_valid/rsp_ready, last set on the final element;
// a dimension mismatch gives a single error beat instead. The user must see
// that dimensions are written on the csr_ port only while the block is
// idle; the block does not enforce it. Each product row of C is formed in
// the cell chain: the row of A is issued from its memory, the elements
// pass through the chain and the MAC stages of the last cell, then the row
// is shifted out one result beat per cycle while the receiver does not
// stall. The chain length sets the fill time. Only one request is worked
// on at a time: req_ready is low while a compute is in progress. The
// result register holds its beat while the receiver stalls, and the drain
// waits with it. Synchronous reset returns the dimensions to 4 and the
// controller to idle; the element stores are left undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mm_pkg::mm_req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mm_pkg::mm_rsp_type               rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mm_pkg::DIM_W-1:0]         csr_data
);

   localparam int DW = $clog2(MAX_DIM);
   localparam int CW = $clog2(MAX_DIM + 1);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);
   localparam int EW = mm_pkg::ELEM_W;

   mm_pkg::mm_state_type state_ff, state_in;
   logic [mm_pkg::DIM_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [CW-1:0] m_eff, k_eff, kb_eff, n_eff;
   logic [DW-1:0] i_ff, i_in, p_ff, p_in, j_ff, j_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mm_pkg::mm_rsp_type rsp_data_ff, rsp_data_in;
   logic          req_fire, load_in_range, out_free;
   logic          issue, load_res, shift_res;
   logic          last_p, last_j, last_i;

   logic signed [EW-1:0] a_mem [MAX_DIM * MAX_DIM];
   logic signed [EW-1:0] a_rd_ff;
   logic [DW-1:0]        feed_p_ff;
   mm_pkg::mm_beat_ctrl_type feed_ctl_ff;

   logic signed [EW-1:0]     chain_a   [MAX_DIM + 1];
   logic [DW-1:0]            chain_p   [MAX_DIM + 1];
   mm_pkg::mm_beat_ctrl_type chain_ctl [MAX_DIM + 1];
   logic signed [EW-1:0]     chain_res [MAX_DIM + 1];
   logic                     cell_done [MAX_DIM];

   function automatic logic [CW-1:0] eff_dim(input logic [mm_pkg::DIM_W-1:0] v);
      logic [CW-1:0] r;
      if (v == '0) begin
         r = CW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = CW'(MAX_DIM);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   assign m_eff  = eff_dim(a_rows_ff);
   assign k_eff  = eff_dim(a_cols_ff);
   assign kb_eff = eff_dim(b_rows_ff);
   assign n_eff  = eff_dim(b_cols_ff);

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == mm_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_in_range = (32'(req_data.row) < MAX_DIM) && (32'(req_data.col) < MAX_DIM);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_p    = (CW'(p_ff) == k_eff - CW'(1));
   assign last_j    = (CW'(j_ff) == n_eff - CW'(1));
   assign last_i    = (CW'(i_ff) == m_eff - CW'(1));

   // Dimension registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= mm_pkg::DIM_W'(4);
         a_cols_ff <= mm_pkg::DIM_W'(4);
         b_rows_ff <= mm_pkg::DIM_W'(4);
         b_cols_ff <= mm_pkg::DIM_W'(4);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mm_pkg::REG_A_ROWS: a_rows_ff <= csr_data;
            mm_pkg::REG_A_COLS: a_cols_ff <= csr_data;
            mm_pkg::REG_B_ROWS: b_rows_ff <= csr_data;
            mm_pkg::REG_B_COLS: b_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Store of A, written by load beats and read row by row during a compute.
   always_ff @(posedge clock) begin
      if (req_fire && req_data.op == mm_pkg::OP_LOAD_A && load_in_range) begin
         a_mem[AW'(req_data.row) * AW'(MAX_DIM) + AW'(req_data.col)] <= req_data.value;
      end
      a_rd_ff   <= a_mem[AW'(i_ff) * AW'(MAX_DIM) + AW'(p_ff)];
      feed_p_ff <= p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ctl_ff <= '0;
      end else begin
         feed_ctl_ff.vld   <= issue;
         feed_ctl_ff.first <= (p_ff == '0);
         feed_ctl_ff.last  <= last_p;
      end
   end

   // Controller state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      p_ff        <= p_in;
      j_ff        <= j_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      issue        = 1'b0;
      load_res     = 1'b0;
      shift_res    = 1'b0;
      unique case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (req_fire && req_data.op == mm_pkg::OP_COMPUTE) begin
               i_in = '0;
               p_in = '0;
               if (k_eff != kb_eff) begin
                  state_in = mm_pkg::ST_ERROR;
               end else begin
                  state_in = mm_pkg::ST_ISSUE;
               end
            end
         end
         mm_pkg::ST_ISSUE: begin
            issue = 1'b1;
            p_in  = p_ff + DW'(1);
            if (last_p) begin
               state_in = mm_pkg::ST_WAIT;
            end
         end
         mm_pkg::ST_WAIT: begin
            if (cell_done[MAX_DIM-1]) begin
               load_res = 1'b1;
               j_in     = '0;
               state_in = mm_pkg::ST_DRAIN;
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (out_free) begin
               shift_res            = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_data_in.result   = chain_res[0];
               rsp_data_in.out_row  = 3'(i_ff);
               rsp_data_in.out_col  = 3'(j_ff);
               rsp_data_in.last     = last_i && last_j;
               rsp_data_in.dim_error = 1'b0;
               j_in                 = j_ff + DW'(1);
               if (last_j) begin
                  if (last_i) begin
                     state_in = mm_pkg::ST_IDLE;
                  end else begin
                     i_in     = i_ff + DW'(1);
                     p_in     = '0;
                     state_in = mm_pkg::ST_ISSUE;
                  end
               end
            end
         end
         mm_pkg::ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.result    = '0;
               rsp_data_in.out_row   = '0;
               rsp_data_in.out_col   = '0;
               rsp_data_in.last      = 1'b1;
               rsp_data_in.dim_error = 1'b1;
               state_in              = mm_pkg::ST_IDLE;
            end
         end
         default: state_in = mm_pkg::ST_IDLE;
      endcase
   end

   // Chain of cells; cell j owns column j of B.
   assign chain_a[0]         = a_rd_ff;
   assign chain_p[0]         = feed_p_ff;
   assign chain_ctl[0]       = feed_ctl_ff;
   assign chain_res[MAX_DIM] = '0;

   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      mm_cell #(
         .MAX_DIM (MAX_DIM)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .a_in      (chain_a[c]),
         .p_in      (chain_p[c]),
         .ctl_in    (chain_ctl[c]),
         .a_out     (chain_a[c+1]),
         .p_out     (chain_p[c+1]),
         .ctl_out   (chain_ctl[c+1]),
         .b_we      (req_fire && req_data.op == mm_pkg::OP_LOAD_B && load_in_range
                     && 32'(req_data.col) == c),
         .b_addr    (DW'(req_data.row)),
         .b_data    (req_data.value),
         .load_res  (load_res),
         .shift_res (shift_res),
         .res_in    (chain_res[c+1]),
         .res_out   (chain_res[c]),
         .done      (cell_done[c])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/matrix_multiply_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply testbench
// Loads elements of A and B, writes the dimensions and runs computes, and
// compares every product beat with a local fixed-point prediction. Both
// request and response sides idle at random.
// ----------------------------------------------------------------------------
module matrix_multiply_test;

   localparam int MAX_DIM     = 8;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 200;

   // Codes the block ignores: the unused operation and a register index
   // beyond the last register.
   localparam logic [1:0]                     OP_IGNORED = 2'd3;
   localparam logic [mm_pkg::CSR_IDX_W-1:0]   REG_NONE   = 4'd9;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   mm_pkg::mm_req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   mm_pkg::mm_rsp_type rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [mm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mm_pkg::DIM_W-1:0]     csr_data;

   // Local copy of the element stores and the dimension registers.
   logic signed [mm_pkg::ELEM_W-1:0] elem_a [MAX_DIM*MAX_DIM];
   logic signed [mm_pkg::ELEM_W-1:0] elem_b [MAX_DIM*MAX_DIM];
   logic [mm_pkg::DIM_W-1:0]         dim_reg [4];

   mm_pkg::mm_rsp_type product_queue [$];
   int         mismatch_count;
   int         cycle_count;

   matrix_multiply #(.MAX_DIM(MAX_DIM)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic int effective_dim(input logic [mm_pkg::DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Works out the product beats that one compute emits.
   task automatic predict_product();
      int m, k, kb, n;
      longint acc, shifted;
      mm_pkg::mm_rsp_type beat;
      m  = effective_dim(dim_reg[mm_pkg::REG_A_ROWS[1:0]]);
      k  = effective_dim(dim_reg[mm_pkg::REG_A_COLS[1:0]]);
      kb = effective_dim(dim_reg[mm_pkg::REG_B_ROWS[1:0]]);
      n  = effective_dim(dim_reg[mm_pkg::REG_B_COLS[1:0]]);
      if (k != kb) begin
         beat = '0;
         beat.last = 1'b1;
         beat.dim_error = 1'b1;
         product_queue.push_back(beat);
         return;
      end
      for (int i = 0; i < m; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int p = 0; p < k; p++)
               acc += longint'(elem_a[i*MAX_DIM+p]) * longint'(elem_b[p*MAX_DIM+j]);
            shifted = acc >>> mm_pkg::FRAC_BITS;
            if (shifted > 32767) shifted = 32767;
            if (shifted < -32768) shifted = -32768;
            beat.result    = shifted[mm_pkg::ELEM_W-1:0];
            beat.out_row   = i[2:0];
            beat.out_col   = j[2:0];
            beat.last      = (i == m-1) && (j == n-1);
            beat.dim_error = 1'b0;
            product_queue.push_back(beat);
         end
      end
   endtask

   // Sends one request beat after a random gap (none with no_gap) and updates the prediction.
   // Valid stays high after the beat is taken so that a following beat can
   // go back to back; a gap or stop_requests drops it.
   task automatic send_request(input logic [1:0] op, input logic [2:0] row,
                               input logic [2:0] col,
                               input logic [mm_pkg::ELEM_W-1:0] value,
                               input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data.op    <= op;
      req_data.row   <= row;
      req_data.col   <= col;
      req_data.value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         mm_pkg::OP_LOAD_A: elem_a[row*MAX_DIM+col] = value;
         mm_pkg::OP_LOAD_B: elem_b[row*MAX_DIM+col] = value;
         mm_pkg::OP_COMPUTE: predict_product();
         default: ;
      endcase
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      stop_requests();
      while (product_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_dim(input logic [mm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mm_pkg::DIM_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= mm_pkg::REG_B_COLS) dim_reg[idx[1:0]] = v;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_dims(input logic [mm_pkg::DIM_W-1:0] ar,
                           input logic [mm_pkg::DIM_W-1:0] ac,
                           input logic [mm_pkg::DIM_W-1:0] br,
                           input logic [mm_pkg::DIM_W-1:0] bc);
      wait_idle();
      write_dim(mm_pkg::REG_A_ROWS, ar);
      write_dim(mm_pkg::REG_A_COLS, ac);
      write_dim(mm_pkg::REG_B_ROWS, br);
      write_dim(mm_pkg::REG_B_COLS, bc);
   endtask

   // Fills every element of both stores so no compute reads an unwritten one.
   task automatic test_fill_stores();
      for (int r = 0; r < MAX_DIM; r++)
         for (int c = 0; c < MAX_DIM; c++) begin
            send_request(mm_pkg::OP_LOAD_A, 3'(r), 3'(c), 16'(r*256 + c*64 - 700), 1);
            send_request(mm_pkg::OP_LOAD_B, 3'(r), 3'(c), 16'(c*128 - r*96 + 300), 1);
         end
   endtask

   // Extreme element values, saturation both ways and the ignored op.
   task automatic test_directed();
      set_dims(4'd2, 4'd2, 4'd2, 4'd2);
      send_request(mm_pkg::OP_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
      send_request(mm_pkg::OP_LOAD_A, 3'd0, 3'd1, 16'h7FFF);
      send_request(mm_pkg::OP_LOAD_A, 3'd1, 3'd0, 16'h8000);
      send_request(mm_pkg::OP_LOAD_A, 3'd1, 3'd1, 16'h0100);
      send_request(mm_pkg::OP_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
      send_request(mm_pkg::OP_LOAD_B, 3'd1, 3'd0, 16'h7FFF);
      send_request(mm_pkg::OP_LOAD_B, 3'd0, 3'd1, 16'h8000);
      send_request(mm_pkg::OP_LOAD_B, 3'd1, 3'd1, 16'hFFFF);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      send_request(OP_IGNORED, 3'd7, 3'd7, 16'h5A5A);
      send_request(mm_pkg::OP_LOAD_B, 3'd7, 3'd7, 16'hFFFF);
      send_request(mm_pkg::OP_LOAD_A, 3'd7, 3'd7, 16'h0001);
      send_request(mm_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
   endtask

   // Mismatched inner dimensions, register zero and values above the limit.
   task automatic test_dimension_cases();
      set_dims(4'd3, 4'd2, 4'd5, 4'd3);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      set_dims(4'd0, 4'd0, 4'd0, 4'd0);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      set_dims(4'd15, 4'd9, 4'd8, 4'd15);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      set_dims(4'd1, 4'd8, 4'd8, 4'd1);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      set_dims(4'd8, 4'd1, 4'd1, 4'd8);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      wait_idle();
      write_dim(REG_NONE, 4'd2);
      send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
   endtask

   // Random loads with computes between, dimensions varied between phases.
   task automatic test_random();
      int kind;
      for (int phase = 0; phase < 6; phase++) begin
         set_dims(4'($urandom_range(0, 15)), 4'($urandom_range(0, 4)),
                  4'($urandom_range(0, 4)), 4'($urandom_range(0, 15)));
         for (int n = 0; n < 15; n++) begin
            kind = $urandom_range(0, 19);
            if (kind < 17)
               send_request(kind[0] ? mm_pkg::OP_LOAD_B : mm_pkg::OP_LOAD_A,
                            3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                            16'($urandom()));
            else if (kind < 19)
               send_request(mm_pkg::OP_COMPUTE, 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)), 16'($urandom()));
            else
               send_request(OP_IGNORED, 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)), 16'($urandom()));
         end
         // Let every product drain before the next compute at least once.
         if (phase == 2) wait_idle();
         send_request(mm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
      end
   endtask

   // Receiver: random stall per beat, checks against the oldest prediction.
   initial begin
      int stall;
      mm_pkg::mm_rsp_type want;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (product_queue.size() == 0) begin
            report_mismatch("product beat with none expected");
         end else begin
            want = product_queue.pop_front();
            if (rsp_data.result !== want.result)
               report_mismatch($sformatf("result %0d, expected %0d",
                                         rsp_data.result, want.result));
            if (rsp_data.out_row !== want.out_row)
               report_mismatch($sformatf("out_row %0d, expected %0d",
                                         rsp_data.out_row, want.out_row));
            if (rsp_data.out_col !== want.out_col)
               report_mismatch($sformatf("out_col %0d, expected %0d",
                                         rsp_data.out_col, want.out_col));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_data.last, want.last));
            if (rsp_data.dim_error !== want.dim_error)
               report_mismatch($sformatf("dim_error %0b, expected %0b",
                                         rsp_data.dim_error, want.dim_error));
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      mismatch_count = 0;
      cycle_count    = 0;
      for (int i = 0; i < 4; i++) dim_reg[i] = 4'd4;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_stores();
      test_directed();
      test_dimension_cases();
      test_random();
      wait_idle();
      if (mismatch_count == 0 && product_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
